[rtl/core/cbu_pkg.sv]
// Shared types and constants for the comment blanker.
package cbu_pkg;

   localparam logic [7:0] CharSlash = 8'h2F;
   localparam logic [7:0] CharStar  = 8'h2A;
   localparam logic [7:0] CharNl    = 8'h0A;
   localparam logic [7:0] CharSpace = 8'h20;

   localparam int QueueDepth = 4;
   localparam int PtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntW       = $clog2(QueueDepth + 1);

   typedef enum logic [2:0] {
      MODE_CODE  = 3'b001,
      MODE_LINE  = 3'b010,
      MODE_BLOCK = 3'b100
   } mode_type;

   // Results caused by one input item; the second one is always the final character.
   typedef struct packed {
      logic       first_valid;
      logic [7:0] first_char;
      logic       second_valid;
      logic [7:0] second_char;
   } pair_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

[rtl/core/cbu_front.sv]
// Front end: accepts characters, tracks comment mode and decides each held character.
module cbu_front
   import cbu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [7:0]       req_char_in,
   input  logic             req_last_in,
   input  queue_status_type q_status,
   output logic             req_stall,
   output logic             push,
   output pair_type         push_data
);

   mode_type   mode_ff, mode_in;
   logic [7:0] held_char_ff, held_char_in;
   logic       held_valid_ff, held_valid_in;
   logic       held_blank_ff, held_blank_in;

   logic       accept;
   logic       nxt_blank;
   logic [7:0] held_out;
   mode_type   mode_dec;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   // Decide the held character with the incoming one as lookahead.
   always_comb begin
      mode_dec  = mode_ff;
      nxt_blank = 1'b0;
      held_out  = held_char_ff;
      if (held_blank_ff) begin
         held_out = CharSpace;
      end else begin
         case (mode_ff)
            MODE_LINE: begin
               if (held_char_ff == CharNl) begin
                  mode_dec = MODE_CODE;
               end else begin
                  held_out = CharSpace;
               end
            end
            MODE_BLOCK: begin
               held_out = CharSpace;
               if (held_char_ff == CharStar && req_char_in == CharSlash) begin
                  nxt_blank = 1'b1;
                  mode_dec  = MODE_CODE;
               end
            end
            default: begin
               mode_dec = MODE_CODE;
               if (held_char_ff == CharSlash && req_char_in == CharSlash) begin
                  mode_dec = MODE_LINE;
                  held_out = CharSpace;
               end else if (held_char_ff == CharSlash && req_char_in == CharStar) begin
                  mode_dec = MODE_BLOCK;
                  held_out = CharSpace;
               end
            end
         endcase
      end
   end

   always_comb begin
      push_data.first_valid  = held_valid_ff;
      push_data.first_char   = held_out;
      push_data.second_valid = req_last_in;
      push_data.second_char  = (held_valid_ff && nxt_blank) ? CharSpace : req_char_in;
      push = accept && (held_valid_ff || req_last_in);

      mode_in       = mode_ff;
      held_char_in  = held_char_ff;
      held_valid_in = held_valid_ff;
      held_blank_in = held_blank_ff;
      if (accept) begin
         if (req_last_in) begin
            mode_in       = MODE_CODE;
            held_char_in  = '0;
            held_valid_in = 1'b0;
            held_blank_in = 1'b0;
         end else begin
            mode_in       = held_valid_ff ? mode_dec : mode_ff;
            held_char_in  = req_char_in;
            held_valid_in = 1'b1;
            held_blank_in = held_valid_ff && nxt_blank;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_CODE;
         held_char_ff  <= '0;
         held_valid_ff <= 1'b0;
         held_blank_ff <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         held_char_ff  <= held_char_in;
         held_valid_ff <= held_valid_in;
         held_blank_ff <= held_blank_in;
      end
   end

endmodule

[rtl/core/cbu_queue.sv]
// Short queue of decided result pairs between front and back.
module cbu_queue
   import cbu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pair_type         push_data,
   input  logic             pop,
   output pair_type         pop_data,
   output queue_status_type status
);

   pair_type            mem [QueueDepth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CntW'(QueueDepth));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/core/cbu_back.sv]
// Back end: unpacks queued pairs into single result items behind an output register.
module cbu_back
   import cbu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  pair_type         pop_data,
   input  queue_status_type q_status,
   output logic             pop,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output logic [7:0]       rsp_char_out,
   output logic             rsp_last_out
);

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_char_ff, out_char_in;
   logic       out_last_ff, out_last_in;
   logic       pend_valid_ff, pend_valid_in;
   logic [7:0] pend_char_ff, pend_char_in;
   logic       out_free;

   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_char_in   = out_char_ff;
      out_last_in   = out_last_ff;
      pend_valid_in = pend_valid_ff;
      pend_char_in  = pend_char_ff;
      pop           = 1'b0;
      if (out_free) begin
         out_valid_in = 1'b0;
         if (pend_valid_ff) begin
            // second half of a pair is always the final character
            out_valid_in  = 1'b1;
            out_char_in   = pend_char_ff;
            out_last_in   = 1'b1;
            pend_valid_in = 1'b0;
         end else if (!q_status.empty) begin
            pop          = 1'b1;
            out_valid_in = 1'b1;
            if (pop_data.first_valid) begin
               out_char_in   = pop_data.first_char;
               out_last_in   = 1'b0;
               pend_valid_in = pop_data.second_valid;
               pend_char_in  = pop_data.second_char;
            end else begin
               out_char_in = pop_data.second_char;
               out_last_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_char_ff  <= out_char_in;
      out_last_ff  <= out_last_in;
      pend_char_ff <= pend_char_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_char_out = out_char_ff;
   assign rsp_last_out = out_last_ff;

endmodule

[rtl/core/comment_blanker_unit.sv]
// Comment blanker top level: replaces C comments in a character stream with spaces.
//
// Usage: characters enter on the req_ channel, one item per character, with
// req_last_in on the final character of a buffer. Results leave on the rsp_
// channel; the text keeps its length and rsp_last_out marks the final one.
// Each character is decided one character late, so the first character of a
// buffer yields no result and the final one yields two (the held character
// and itself). Throughput is one item per cycle while req_stall is low; a
// final character yields one extra output item, which the four-entry queue
// between the front end and the output stage absorbs.
// req_stall rises only when that queue is full, so a stalled receiver backs
// up the queue before the sender sees a stall. The output register holds its
// item steady while rsp_stall is high. Reset clears mode, held character,
// queue and output; each buffer starts in code mode.
module comment_blanker_unit
   import cbu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_in,
   input  logic       req_last_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_char_out,
   output logic       rsp_last_out
);

   logic             push;
   pair_type         push_data;
   logic             pop;
   pair_type         pop_data;
   queue_status_type q_status;

   cbu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_char_in (req_char_in),
      .req_last_in (req_last_in),
      .q_status    (q_status),
      .req_stall   (req_stall),
      .push        (push),
      .push_data   (push_data)
   );

   cbu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   cbu_back u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_data     (pop_data),
      .q_status     (q_status),
      .pop          (pop),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_char_out (rsp_char_out),
      .rsp_last_out (rsp_last_out)
   );

   a_reset_out_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_reset_no_stall: assert property (@(posedge clock) reset |=> !req_stall)
      else $error("input stalled right after reset");

   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue both full and empty");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("push into full queue");

endmodule

[tb/sv/comment_blanker_unit_tb.sv]
// Testbench for comment_blanker_unit: random C-like text checked against a blanking predictor.
`timescale 1ns / 100ps

module comment_blanker_unit_tb;
   import cbu_pkg::*;

   localparam int CycleLimit = 200000;
   localparam int HoldCycles = 64;
   localparam int DrainCycles = 20;

   class blanker_scoreboard;
      typedef struct packed {
         logic [7:0] ch;
         logic       last;
      } text_char_type;

      mode_type      mode;
      logic [7:0]    held_char;
      bit            held_valid;
      bit            held_blank;
      text_char_type due_chars[$];
      int            mismatches;
      int            checked;

      function new();
         clear_state();
         mismatches = 0;
         checked = 0;
      endfunction

      function void clear_state();
         mode = MODE_CODE;
         held_char = 8'h00;
         held_valid = 1'b0;
         held_blank = 1'b0;
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: mismatch: %s", $realtime, msg);
      endfunction

      // Decide the held char with c as lookahead; c itself is held unless it is final.
      function void take_char(logic [7:0] c, logic last);
         text_char_type r;
         bit            c_blank;
         c_blank = 1'b0;
         if (held_valid) begin
            r.ch = held_char;
            r.last = 1'b0;
            if (held_blank) begin
               r.ch = CharSpace;
            end else begin
               case (mode)
                  MODE_LINE: begin
                     if (held_char == CharNl)
                        mode = MODE_CODE;
                     else
                        r.ch = CharSpace;
                  end
                  MODE_BLOCK: begin
                     r.ch = CharSpace;
                     if (held_char == CharStar && c == CharSlash) begin
                        c_blank = 1'b1;
                        mode = MODE_CODE;
                     end
                  end
                  default: begin
                     if (held_char == CharSlash && c == CharSlash) begin
                        mode = MODE_LINE;
                        r.ch = CharSpace;
                     end else if (held_char == CharSlash && c == CharStar) begin
                        mode = MODE_BLOCK;
                        r.ch = CharSpace;
                     end else begin
                        mode = MODE_CODE;
                     end
                  end
               endcase
            end
            due_chars.push_back(r);
         end
         if (last) begin
            r.ch = c_blank ? CharSpace : c;
            r.last = 1'b1;
            due_chars.push_back(r);
            clear_state();
         end else begin
            held_char = c;
            held_valid = 1'b1;
            held_blank = c_blank;
         end
      endfunction

      function void check_char(logic [7:0] c, logic last);
         text_char_type e;
         checked++;
         if (due_chars.size() == 0) begin
            flag($sformatf("unexpected item char=%02h last=%0b", c, last));
            return;
         end
         e = due_chars.pop_front();
         if (c !== e.ch)
            flag($sformatf("char expected %02h got %02h", e.ch, c));
         if (last !== e.last)
            flag($sformatf("last expected %0b got %0b", e.last, last));
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_in = 8'h00;
   logic       req_last_in = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_char_out;
   logic       rsp_last_out;

   blanker_scoreboard sb = new();

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_go = 1'b0;
   bit  hold_off = 1'b0;
   int  cycles = 0;
   int  chars_sent = 0;
   int  buffers_sent = 0;
   int  input_stalls = 0;
   logic [7:0] text_buf[$];

   comment_blanker_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_char_in (req_char_in),
      .req_last_in (req_last_in),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_char_out(rsp_char_out),
      .rsp_last_out(rsp_last_out)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Receiver: check each accepted item, then pick the stall for the next cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            sb.check_char(rsp_char_out, rsp_last_out);
         rsp_stall <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Long output hold-off while the sender keeps going, to fill the internal queue.
   initial begin
      wait (hold_go);
      repeat (5) @(posedge clock);
      hold_off <= 1'b1;
      repeat (HoldCycles) @(posedge clock);
      hold_off <= 1'b0;
   end

   task automatic send_char(input logic [7:0] c, input logic last);
      int gap;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_in <= c;
      req_last_in <= last;
      @(posedge clock);
      while (req_stall) begin
         input_stalls++;
         @(posedge clock);
      end
      sb.take_char(c, last);
      chars_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], i == s.len() - 1);
      buffers_sent++;
   endtask

   function automatic logic [7:0] pick_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 18) return CharSlash;
      if (r < 33) return CharStar;
      if (r < 42) return CharNl;
      if (r < 50) return CharSpace;
      if (r < 88) return 8'($urandom_range(8'h61, 8'h7A));
      return 8'($urandom_range(0, 255));
   endfunction

   // One piece of text: plain code, a line comment, a block comment, or noise.
   function automatic void add_segment();
      int kind;
      int n;
      kind = $urandom_range(0, 9);
      n = $urandom_range(0, 6);
      case (kind)
         0, 1, 2: begin
            repeat (n) text_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
         end
         3, 4: begin
            text_buf.push_back(CharSlash);
            text_buf.push_back(CharSlash);
            repeat (n) text_buf.push_back(pick_char());
            if ($urandom_range(0, 3) != 0) text_buf.push_back(CharNl);
         end
         5, 6: begin
            text_buf.push_back(CharSlash);
            text_buf.push_back(CharStar);
            repeat (n) text_buf.push_back(pick_char());
            if ($urandom_range(0, 3) != 0) begin
               text_buf.push_back(CharStar);
               text_buf.push_back(CharSlash);
            end
         end
         default: begin
            repeat (n) text_buf.push_back(pick_char());
         end
      endcase
   endfunction

   task automatic send_random_text(input int n_chars);
      int sent;
      int segs;
      sent = 0;
      while (sent < n_chars) begin
         text_buf.delete();
         segs = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
         repeat (segs) add_segment();
         if (text_buf.size() == 0) text_buf.push_back(pick_char());
         for (int i = 0; i < text_buf.size(); i++)
            send_char(text_buf[i], i == text_buf.size() - 1);
         buffers_sent++;
         sent += text_buf.size();
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 10;
      recv_idle_pct = 46;
      // a single-char buffer and a two-char buffer at the field extremes
      send_char(8'hFF, 1'b1);
      buffers_sent++;
      send_char(8'h00, 1'b0);
      send_char(CharSlash, 1'b1);
      buffers_sent++;
      send_text("//a\nb");     // line comment, newline kept
      send_text("/*/x");       // block closes at once
      send_text("/**/");       // final slash of a close is blanked
      send_text("/*a*");       // buffer ends inside a block comment
      send_text("a/*");        // final star not blanked

      send_random_text(560);
      send_idle_pct = 46;
      recv_idle_pct = 10;
      send_random_text(560);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_go = 1'b1;
      send_random_text(570);

      req_valid <= 1'b0;
      while (sb.due_chars.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Sent %0d chars in %0d buffers; %0d output items checked.",
               chars_sent, buffers_sent, sb.checked);
      $display("Idle mixes 10/46, 46/10 and none; input stalled %0d cycles %s %0d cycles.",
               input_stalls, "around an output hold-off of", HoldCycles);
      if (sb.mismatches == 0 && sb.due_chars.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
